### hw/rtl/ucblac_pkg.sv
// Shared types and constants of the late acceptance controller with UCB1 operator picker.
package ucblac_pkg;

	localparam int HIST_DEPTH = 512;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int NUM_OPS    = 6;
	localparam int OP_W       = 3;
	localparam int OBJ_W      = 32;
	localparam int CNT_W      = 6;

	// Restoring divider: 38-bit dividend covers ln(x) in Q.16 shifted up by 16
	localparam int DIV_W      = 38;
	localparam int DIV_ITERS  = DIV_W;
	localparam int LOG_ITERS  = 16;
	localparam int GAIN_ITERS = 16;
	localparam int SQRT_ITERS = DIV_W / 2;
	localparam int SCORE_W    = 29;

	localparam logic [15:0] LN2_Q16 = 16'd45426;

	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_REPORT = 1'b1;

	localparam logic [7:0] REG_UCB_WEIGHT     = 8'd0;
	localparam logic [7:0] REG_HISTORY_LENGTH = 8'd1;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_READ,
		ST_CHECK,
		ST_GAIN,
		ST_MEAN,
		ST_MEAN_DIV,
		ST_MEAN_APPLY,
		ST_PICK,
		ST_NORM,
		ST_SQUARE,
		ST_LN,
		ST_QSET,
		ST_QDIV,
		ST_SQRT,
		ST_SCORE,
		ST_CHOOSE,
		ST_OUT
	} state_t;

endpackage

### hw/rtl/ucblac_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ucblac_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hw/rtl/ucb_late_acceptance_controller.sv
// Top level of the late acceptance search controller with a UCB1 operator picker.
//
// Input words arrive on s_axis: tuser[0] is the command (0 start, 1 report),
// tuser[1] the feasible flag, tdata the objective in unsigned Q16.16.
// A start word loads current, best and all history slots with the objective,
// clears the operator statistics and picks operator 0. A report word runs the
// late acceptance test if feasible, updates the mean reward of the picked
// operator and picks the next one (untried first, else the highest UCB1 score).
// Each input word gives one result word on m_axis.
// The block works on one word at a time and drops s_axis_tready meanwhile.
// A start sweeps the history, writing one slot per cycle through the single
// RAM write port. A feasible report runs a 38-step divider for the history
// slot and, for an accepted lower nonzero objective, 16 steps of reward division.
// Then every report runs a 38-step divider for the mean and, once every operator has
// been tried, up to 32 normalize steps, 16 squaring steps for log2, and for each
// of the six operators a 38-step division and a 19-step square root, back to back.
// After reset the block sweeps the history RAM with zeros and takes no input
// word in that time; configuration writes are always taken.
// A finished result waits in the output register while m_axis_tready is low;
// the block then holds the next result until the register frees up.
module ucb_late_acceptance_controller
	import ucblac_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input word
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] objective
	input  logic [1:0]  s_axis_tuser,   // [0] cmd, [1] feasible
	// result word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [2:0] next_operator, [3] accepted,
	                                    // [4] new_best, [36:5] current_objective,
	                                    // [68:37] best_objective, [71:69] zero
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	state_t state_q, state_d;

	logic [23:0]          ucb_weight_q;
	logic [9:0]           hist_len_q;
	logic [9:0]           len_eff;

	logic [HIST_AW:0]     clr_addr_q;
	logic [OBJ_W-1:0]     fill_q;
	logic                 start_q;

	logic [OBJ_W-1:0]     cur_q, best_q, obj_q;
	logic [31:0]          step_q;
	logic [31:0]          tc_q [NUM_OPS];
	logic [15:0]          mean_q [NUM_OPS];
	logic [OP_W-1:0]      chosen_q;

	logic [HIST_AW-1:0]   pos_q;
	logic                 acc_q, nb_q;
	logic [15:0]          reward_q;
	logic [OBJ_W-1:0]     gr_q;
	logic                 dneg_q;
	logic [CNT_W-1:0]     cnt_q;

	logic [DIV_W-1:0]     num_q, quo_q;
	logic [31:0]          rem_q, dvs_q;

	logic [32:0]          xn_q;
	logic [5:0]           e_q;
	logic [30:0]          z_q;
	logic [15:0]          frac_q;
	logic [21:0]          lnq_q;

	logic [DIV_W-1:0]     rad_q;
	logic [23:0]          srem_q;
	logic [19:0]          root_q;

	logic [OP_W-1:0]      op_q, bop_q;
	logic [SCORE_W-1:0]   bscore_q;

	logic                 m_valid_q;
	logic [OP_W-1:0]      res_op_q;
	logic                 res_acc_q, res_nb_q;
	logic [OBJ_W-1:0]     res_cur_q, res_best_q;

	logic                 ram_wr_en, ram_rd_en;
	logic [HIST_AW-1:0]   ram_wr_addr;
	logic [OBJ_W-1:0]     ram_wr_data, ram_rd_data;

	logic                 in_fire, out_free;
	logic [32:0]          div_sh;
	logic                 div_ge;
	logic [OBJ_W-1:0]     gain_diff;
	logic [61:0]          sq_prod;
	logic [37:0]          ln_prod;
	logic [43:0]          bonus_prod;
	logic [SCORE_W-1:0]   score;
	logic [23:0]          sq_sh, sq_trial;
	logic                 untried;
	logic [OP_W-1:0]      untried_op;
	logic [16:0]          mean_diff;
	logic                 cmp_acc;
	logic                 last_op;

	// Read the slot from the finished remainder while pos_q is loaded
	ucblac_ram #(.WIDTH(OBJ_W), .DEPTH(HIST_DEPTH)) u_hist (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (rem_q[HIST_AW-1:0]),
		.rd_data (ram_rd_data)
	);

	// Clamp the history length into 1..HIST_DEPTH
	always_comb begin
		len_eff = hist_len_q;
		if (hist_len_q == '0) begin
			len_eff = 10'd1;
		end else if ({22'd0, hist_len_q} > HIST_DEPTH) begin
			len_eff = 10'(HIST_DEPTH);
		end
	end

	// Shared arithmetic for the iterative steps
	always_comb begin
		div_sh     = {rem_q, num_q[DIV_W-1]};
		div_ge     = div_sh >= {1'b0, dvs_q};
		gain_diff  = dvs_q - gr_q;
		sq_prod    = {31'd0, z_q} * {31'd0, z_q};
		ln_prod    = {e_q, frac_q} * LN2_Q16;
		bonus_prod = {20'd0, ucb_weight_q} * {24'd0, root_q};
		score      = SCORE_W'({13'd0, mean_q[op_q]}) + SCORE_W'(bonus_prod[43:16]);
		sq_sh      = {srem_q[21:0], rad_q[DIV_W-1 -: 2]};
		sq_trial   = {2'b00, root_q, 2'b01};
		mean_diff  = {1'b0, reward_q} - {1'b0, mean_q[chosen_q]};
		cmp_acc    = (obj_q <= cur_q) || (obj_q <= ram_rd_data);
		last_op    = op_q == OP_W'(NUM_OPS - 1);
	end

	// Find the lowest operator not yet tried
	always_comb begin
		untried    = 1'b0;
		untried_op = '0;
		for (int i = NUM_OPS - 1; i >= 0; i--) begin
			if (tc_q[i] == '0) begin
				untried    = 1'b1;
				untried_op = OP_W'(i);
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == (HIST_AW+1)'(HIST_DEPTH - 1)) begin
					state_d = start_q ? ST_OUT : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					if (s_axis_tuser[0] == CMD_START) begin
						state_d = ST_CLEAR;
					end else if (s_axis_tuser[1]) begin
						state_d = ST_MOD;
					end else begin
						state_d = ST_MEAN;
					end
				end
			end
			ST_MOD: begin
				if (cnt_q == CNT_W'(DIV_ITERS - 1)) state_d = ST_READ;
			end
			ST_READ:  state_d = ST_CHECK;
			ST_CHECK: begin
				if (cmp_acc && obj_q < cur_q && obj_q != '0) begin
					state_d = ST_GAIN;
				end else begin
					state_d = ST_MEAN;
				end
			end
			ST_GAIN: begin
				if (cnt_q == CNT_W'(GAIN_ITERS - 1)) state_d = ST_MEAN;
			end
			ST_MEAN: state_d = ST_MEAN_DIV;
			ST_MEAN_DIV: begin
				if (cnt_q == CNT_W'(DIV_ITERS - 1)) state_d = ST_MEAN_APPLY;
			end
			ST_MEAN_APPLY: state_d = ST_PICK;
			ST_PICK:  state_d = untried ? ST_OUT : ST_NORM;
			ST_NORM: begin
				if (xn_q[32]) state_d = ST_SQUARE;
			end
			ST_SQUARE: begin
				if (cnt_q == CNT_W'(LOG_ITERS - 1)) state_d = ST_LN;
			end
			ST_LN:   state_d = ST_QSET;
			ST_QSET: state_d = ST_QDIV;
			ST_QDIV: begin
				if (cnt_q == CNT_W'(DIV_ITERS - 1)) state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (cnt_q == CNT_W'(SQRT_ITERS - 1)) state_d = ST_SCORE;
			end
			ST_SCORE:  state_d = last_op ? ST_CHOOSE : ST_QSET;
			ST_CHOOSE: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake and RAM controls
	always_comb begin
		s_axis_tready = state_q == ST_IDLE;
		cfg_ready     = 1'b1;
		in_fire       = s_axis_tvalid && s_axis_tready;
		out_free      = !m_valid_q || m_axis_tready;
		ram_rd_en     = state_q == ST_READ;
		ram_wr_en     = 1'b0;
		ram_wr_addr   = pos_q;
		ram_wr_data   = cur_q;
		case (state_q)
			ST_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = clr_addr_q[HIST_AW-1:0];
				ram_wr_data = fill_q;
			end
			ST_CHECK: ram_wr_en = 1'b1;
			default:  ram_wr_en = 1'b0;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ucb_weight_q <= 24'd65536;
			hist_len_q   <= 10'd50;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_UCB_WEIGHT:     ucb_weight_q <= cfg_data;
				REG_HISTORY_LENGTH: hist_len_q   <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Sequencer and search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			fill_q     <= '0;
			start_q    <= 1'b0;
			cur_q      <= '0;
			best_q     <= '0;
			step_q     <= '0;
			chosen_q   <= '0;
			cnt_q      <= '0;
			acc_q      <= 1'b0;
			nb_q       <= 1'b0;
			for (int i = 0; i < NUM_OPS; i++) begin
				tc_q[i]   <= '0;
				mean_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_CLEAR: clr_addr_q <= clr_addr_q + 1'b1;
				ST_IDLE: begin
					if (in_fire) begin
						obj_q    <= s_axis_tdata;
						acc_q    <= 1'b0;
						nb_q     <= 1'b0;
						reward_q <= '0;
						cnt_q    <= '0;
						if (s_axis_tuser[0] == CMD_START) begin
							// Load start state; operator 0 is picked first
							cur_q      <= s_axis_tdata;
							best_q     <= s_axis_tdata;
							fill_q     <= s_axis_tdata;
							clr_addr_q <= '0;
							start_q    <= 1'b1;
							step_q     <= '0;
							chosen_q   <= '0;
							for (int i = 0; i < NUM_OPS; i++) begin
								tc_q[i]   <= (i == 0) ? 32'd1 : 32'd0;
								mean_q[i] <= '0;
							end
						end else begin
							num_q <= DIV_W'(step_q);
							dvs_q <= 32'(len_eff);
							rem_q <= '0;
						end
					end
				end
				ST_MOD, ST_MEAN_DIV, ST_QDIV: begin
					// One restoring division step
					num_q <= num_q << 1;
					if (div_ge) begin
						rem_q <= 32'(div_sh - {1'b0, dvs_q});
						quo_q <= {quo_q[DIV_W-2:0], 1'b1};
					end else begin
						rem_q <= div_sh[31:0];
						quo_q <= {quo_q[DIV_W-2:0], 1'b0};
					end
					if (state_q == ST_QDIV && cnt_q == CNT_W'(DIV_ITERS - 1)) begin
						rad_q  <= div_ge ? {quo_q[DIV_W-2:0], 1'b1} : {quo_q[DIV_W-2:0], 1'b0};
						srem_q <= '0;
						root_q <= '0;
						cnt_q  <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_READ: begin
					pos_q <= rem_q[HIST_AW-1:0];
				end
				ST_CHECK: begin
					// Late acceptance test; the slot takes the old current
					acc_q <= cmp_acc;
					dvs_q <= cur_q;
					gr_q  <= cur_q - obj_q;
					cnt_q <= '0;
					if (cmp_acc) begin
						cur_q <= obj_q;
						if (obj_q < best_q) begin
							best_q <= obj_q;
							nb_q   <= 1'b1;
						end
						if (obj_q < cur_q && obj_q == '0) begin
							reward_q <= 16'hFFFF;
						end
					end
				end
				ST_GAIN: begin
					// One bit of (cur - cand) / cur
					if (gr_q >= gain_diff) begin
						gr_q     <= gr_q - gain_diff;
						reward_q <= {reward_q[14:0], 1'b1};
					end else begin
						gr_q     <= gr_q << 1;
						reward_q <= {reward_q[14:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_MEAN: begin
					dneg_q <= mean_diff[16];
					num_q  <= DIV_W'(mean_diff[16] ? 17'(-mean_diff) : mean_diff);
					dvs_q  <= (tc_q[chosen_q] == '0) ? 32'd1 : tc_q[chosen_q];
					rem_q  <= '0;
					cnt_q  <= '0;
				end
				ST_MEAN_APPLY: begin
					mean_q[chosen_q] <= dneg_q ? mean_q[chosen_q] - quo_q[15:0]
					                           : mean_q[chosen_q] + quo_q[15:0];
					step_q <= step_q + 1'b1;
				end
				ST_PICK: begin
					if (untried) begin
						chosen_q         <= untried_op;
						tc_q[untried_op] <= tc_q[untried_op] + 1'b1;
					end else begin
						xn_q <= {1'b0, step_q} + 33'd2;
						e_q  <= 6'd32;
					end
				end
				ST_NORM: begin
					// Shift until the top bit leads; e counts the position
					if (xn_q[32]) begin
						z_q    <= xn_q[32:2];
						frac_q <= '0;
						cnt_q  <= '0;
					end else begin
						xn_q <= xn_q << 1;
						e_q  <= e_q - 1'b1;
					end
				end
				ST_SQUARE: begin
					// One fraction bit of log2 by squaring
					if (sq_prod[61]) begin
						z_q    <= sq_prod[61:31];
						frac_q <= {frac_q[14:0], 1'b1};
					end else begin
						z_q    <= sq_prod[60:30];
						frac_q <= {frac_q[14:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_LN: begin
					lnq_q <= ln_prod[37:16];
					op_q  <= '0;
				end
				ST_QSET: begin
					num_q <= {lnq_q, 16'd0};
					dvs_q <= tc_q[op_q];
					rem_q <= '0;
					cnt_q <= '0;
				end
				ST_SQRT: begin
					// One root bit per step, two radicand bits consumed
					rad_q <= rad_q << 2;
					if (sq_sh >= sq_trial) begin
						srem_q <= sq_sh - sq_trial;
						root_q <= {root_q[18:0], 1'b1};
					end else begin
						srem_q <= sq_sh;
						root_q <= {root_q[18:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_SCORE: begin
					if (op_q == '0 || score > bscore_q) begin
						bscore_q <= score;
						bop_q    <= op_q;
					end
					op_q <= op_q + 1'b1;
				end
				ST_CHOOSE: begin
					chosen_q <= bop_q;
					if (tc_q[bop_q] != 32'hFFFF_FFFF) begin
						tc_q[bop_q] <= tc_q[bop_q] + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) start_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Output register: hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			res_op_q   <= chosen_q;
			res_acc_q  <= acc_q;
			res_nb_q   <= nb_q;
			res_cur_q  <= cur_q;
			res_best_q <= best_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {3'd0, res_best_q, res_cur_q, res_nb_q, res_acc_q, res_op_q};

	// Picked operator stays in range
	a_chosen_range: assert property (@(posedge clk) disable iff (!arst_n)
		chosen_q < OP_W'(NUM_OPS))
		else $error("chosen operator out of range");

	// A new best is only reported for an accepted candidate
	a_best_implies_acc: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_nb_q |-> res_acc_q)
		else $error("new best without acceptance");

	// Best never exceeds current in a delivered result
	a_best_le_cur: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> res_best_q <= res_cur_q)
		else $error("best above current");

	// No input word is taken while the history sweep runs
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !s_axis_tready)
		else $error("input taken during history sweep");

endmodule

### tb/testbench.sv
// Self-checking testbench for the late acceptance controller with UCB1 operator picker.
`timescale 1ns / 100ps

module testbench;
	import ucblac_pkg::*;

	localparam logic [7:0] REG_UNUSED = 8'd2;
	localparam int LIMIT_CYCLES = 3_000_000;

	typedef struct {
		logic        cmd;
		logic        feasible;
		logic [31:0] objective;
	} search_word_t;

	typedef struct {
		logic [2:0]  next_op;
		logic        accepted;
		logic        new_best;
		logic [31:0] cur_obj;
		logic [31:0] top_obj;
	} step_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [23:0] cfg_data;

	ucb_late_acceptance_controller DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state
	logic [23:0] pr_weight;
	logic [9:0]  pr_hist_len;
	logic [31:0] pr_current;
	logic [31:0] pr_best;
	logic [31:0] pr_history [HIST_DEPTH];
	logic [31:0] pr_steps;
	logic [31:0] pr_picks [NUM_OPS];
	logic [31:0] pr_mean [NUM_OPS];
	logic [2:0]  pr_chosen;

	search_word_t pending_words[$];
	step_result_t outcome_q[$];

	int errors;
	int words_in;
	int results_out;
	int rejects_seen;
	int bests_seen;
	int hold_cycles;
	bit hold_done;
	bit s_taken;

	// Clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// log2 in Q.16 by repeated squaring of the mantissa
	function automatic logic [63:0] log2_fixed(input logic [63:0] x);
		int unsigned e;
		logic [63:0] z;
		logic [63:0] frac;
		e = 0;
		frac = 0;
		while (e < 63 && (x >> (e + 1)) != 0)
			e++;
		if (e <= 30)
			z = x << (30 - e);
		else
			z = x >> (e - 30);
		for (int i = 0; i < 16; i++) begin
			z = (z * z) >> 30;
			frac = frac << 1;
			if (z >= (64'd2 << 30)) begin
				z = z >> 1;
				frac[0] = 1'b1;
			end
		end
		return (64'(e) << 16) | frac;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Untried operator first, else highest UCB1 score, ties to lowest index
	function automatic logic [2:0] pick_operator();
		logic [63:0] lnq;
		logic [63:0] s;
		logic [63:0] score;
		logic [63:0] top;
		logic [2:0]  win;
		for (int i = 0; i < NUM_OPS; i++)
			if (pr_picks[i] == 0)
				return 3'(i);
		lnq = (log2_fixed(64'(pr_steps) + 64'd2) * 64'(LN2_Q16)) >> 16;
		top = 0;
		win = 0;
		for (int i = 0; i < NUM_OPS; i++) begin
			s = int_sqrt((lnq << 16) / 64'(pr_picks[i]));
			score = 64'(pr_mean[i]) + ((64'(pr_weight) * s) >> 16);
			if (i == 0 || score > top) begin
				top = score;
				win = 3'(i);
			end
		end
		return win;
	endfunction

	function automatic logic [31:0] gain_of(input logic [63:0] cur, input logic [63:0] cand);
		logic [63:0] r;
		logic [63:0] q;
		if (cand == 0)
			return 32'd65535;
		r = cur - cand;
		q = 0;
		for (int i = 0; i < 16; i++) begin
			q = q << 1;
			if (r >= cur - r) begin
				r = r - (cur - r);
				q[0] = 1'b1;
			end else begin
				r = r + r;
			end
		end
		return q[31:0];
	endfunction

	task automatic choose_operator(input logic [2:0] k);
		pr_chosen = k;
		if (pr_picks[k] != 32'hFFFF_FFFF)
			pr_picks[k]++;
	endtask

	// Advance the search state by one word and queue its result
	task automatic step_controller(input search_word_t w);
		step_result_t res;
		logic [2:0]  k;
		logic [31:0] reward;
		logic [31:0] old;
		int unsigned len;
		int unsigned pos;
		longint      n;
		longint      d;
		res.accepted = 1'b0;
		res.new_best = 1'b0;
		if (w.cmd == CMD_START) begin
			pr_current = w.objective;
			pr_best = w.objective;
			for (int i = 0; i < HIST_DEPTH; i++)
				pr_history[i] = w.objective;
			pr_steps = 0;
			for (int i = 0; i < NUM_OPS; i++) begin
				pr_picks[i] = 0;
				pr_mean[i] = 0;
			end
			choose_operator(pick_operator());
		end else begin
			k = (pr_chosen < NUM_OPS) ? pr_chosen : 3'd0;
			reward = 0;
			if (w.feasible) begin
				len = pr_hist_len;
				if (len < 1)
					len = 1;
				if (len > HIST_DEPTH)
					len = HIST_DEPTH;
				pos = pr_steps % len;
				old = pr_current;
				if (w.objective <= old || w.objective <= pr_history[pos])
					res.accepted = 1'b1;
				pr_history[pos] = old;
				if (res.accepted) begin
					if (w.objective < old)
						reward = gain_of(old, w.objective);
					pr_current = w.objective;
					if (w.objective < pr_best) begin
						pr_best = w.objective;
						res.new_best = 1'b1;
					end
				end
			end
			n = (pr_picks[k] != 0) ? longint'(pr_picks[k]) : 1;
			d = longint'(reward) - longint'(pr_mean[k]);
			pr_mean[k] = 32'(longint'(pr_mean[k]) + d / n);
			pr_steps++;
			choose_operator(pick_operator());
		end
		res.next_op = pr_chosen;
		res.cur_obj = pr_current;
		res.top_obj = pr_best;
		outcome_q.push_back(res);
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("result %0d: %s got %0h, wanted %0h", results_out, field, got, want);
	endtask

	// Input side: accept words into the predictor, check result words
	always @(posedge clk) begin
		step_result_t want;
		search_word_t w;
		s_taken = 1'b0;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			w.cmd = s_axis_tuser[0];
			w.feasible = s_axis_tuser[1];
			w.objective = s_axis_tdata;
			step_controller(w);
			words_in++;
			s_taken = 1'b1;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_out++;
			if (outcome_q.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
			end else begin
				want = outcome_q.pop_front();
				if (m_axis_tdata[2:0] !== want.next_op)
					report_mismatch("next_operator", 32'(m_axis_tdata[2:0]), 32'(want.next_op));
				if (m_axis_tdata[3] !== want.accepted)
					report_mismatch("accepted", 32'(m_axis_tdata[3]), 32'(want.accepted));
				if (m_axis_tdata[4] !== want.new_best)
					report_mismatch("new_best", 32'(m_axis_tdata[4]), 32'(want.new_best));
				if (m_axis_tdata[36:5] !== want.cur_obj)
					report_mismatch("current_objective", m_axis_tdata[36:5], want.cur_obj);
				if (m_axis_tdata[68:37] !== want.top_obj)
					report_mismatch("best_objective", m_axis_tdata[68:37], want.top_obj);
				if (!m_axis_tdata[3] && !m_axis_tdata[4])
					rejects_seen++;
				if (m_axis_tdata[4])
					bests_seen++;
			end
		end
	end

	function automatic bit calm_window();
		return words_in >= 420 && words_in < 540;
	endfunction

	// Driver: feed pending words, idling at random outside the calm window
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || s_taken)) begin
			if (pending_words.size() != 0 && (calm_window() || $urandom_range(99) >= 30)) begin
				search_word_t w;
				w = pending_words.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= {w.feasible, w.cmd};
				s_axis_tdata <= w.objective;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: stall at random outside the calm window, or hold off once for a long stretch
	always @(negedge clk) begin
		if (!hold_done && results_out >= 300) begin
			hold_done = 1'b1;
			hold_cycles = 4000;
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm_window() || ($urandom_range(99) >= 30);
		end
	end

	function automatic search_word_t mk_word(input logic cmd, input logic feas,
			input logic [31:0] obj);
		search_word_t w;
		w.cmd = cmd;
		w.feasible = feas;
		w.objective = obj;
		return w;
	endfunction

	task automatic write_register(input logic [7:0] idx, input logic [23:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_UCB_WEIGHT)
			pr_weight = val;
		else if (idx == REG_HISTORY_LENGTH)
			pr_hist_len = val[9:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || s_axis_tvalid || outcome_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Random search run: a start, then drifting reports, random reports and restarts
	task automatic queue_search(input int count);
		logic [31:0] base;
		logic [31:0] span;
		logic [31:0] obj;
		int roll;
		base = $urandom();
		if ($urandom_range(3) == 0)
			base = base >> $urandom_range(24);
		pending_words.push_back(mk_word(CMD_START, 1'($urandom_range(1)), base));
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			span = (base >> 4) + 32'd16;
			if (roll < 2) begin
				base = $urandom();
				pending_words.push_back(mk_word(CMD_START, 1'($urandom_range(1)), base));
			end else if (roll < 15) begin
				pending_words.push_back(mk_word(CMD_REPORT, 1'b0, $urandom()));
			end else if (roll < 25) begin
				pending_words.push_back(mk_word(CMD_REPORT, 1'b1, $urandom()));
			end else begin
				obj = base - span + $urandom_range(span * 2 > span ? span * 2 : span);
				if (obj > base + span && base + span > base)
					obj = base;
				if ($urandom_range(9) == 0)
					base = obj;
				pending_words.push_back(mk_word(CMD_REPORT, 1'b1, obj));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		words_in = 0;
		results_out = 0;
		rejects_seen = 0;
		bests_seen = 0;
		hold_cycles = 0;
		hold_done = 1'b0;
		pr_weight = 24'd65536;
		pr_hist_len = 10'd50;
		pr_current = 0;
		pr_best = 0;
		pr_steps = 0;
		pr_chosen = 0;
		for (int i = 0; i < HIST_DEPTH; i++)
			pr_history[i] = 0;
		for (int i = 0; i < NUM_OPS; i++) begin
			pr_picks[i] = 0;
			pr_mean[i] = 0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reports on the reset state, extremes, every acceptance path
		pending_words.push_back(mk_word(CMD_REPORT, 1'b1, 32'hFFFF_FFFF));
		pending_words.push_back(mk_word(CMD_REPORT, 1'b0, 32'd0));
		pending_words.push_back(mk_word(CMD_REPORT, 1'b1, 32'd0));
		pending_words.push_back(mk_word(CMD_START, 1'b1, 32'hFFFF_FFFF));
		pending_words.push_back(mk_word(CMD_REPORT, 1'b1, 32'hFFFF_FFFF));
		pending_words.push_back(mk_word(CMD_REPORT, 1'b1, 32'h8000_0000));
		pending_words.push_back(mk_word(CMD_REPORT, 1'b1, 32'h9000_0000));
		pending_words.push_back(mk_word(CMD_REPORT, 1'b0, 32'h0000_0001));
		pending_words.push_back(mk_word(CMD_REPORT, 1'b1, 32'h7FFF_FFFF));
		pending_words.push_back(mk_word(CMD_REPORT, 1'b1, 32'h0000_0000));
		pending_words.push_back(mk_word(CMD_REPORT, 1'b1, 32'h0001_0000));
		pending_words.push_back(mk_word(CMD_REPORT, 1'b1, 32'h0000_FFFF));
		pending_words.push_back(mk_word(CMD_REPORT, 1'b1, 32'h5555_5555));
		pending_words.push_back(mk_word(CMD_REPORT, 1'b1, 32'hAAAA_AAAA));
		pending_words.push_back(mk_word(CMD_START, 1'b0, 32'h0000_0000));
		pending_words.push_back(mk_word(CMD_REPORT, 1'b1, 32'h0000_0000));
		pending_words.push_back(mk_word(CMD_REPORT, 1'b1, 32'h0000_0001));
		pending_words.push_back(mk_word(CMD_REPORT, 1'b0, 32'hFFFF_FFFF));
		pending_words.push_back(mk_word(CMD_START, 1'b0, 32'h0010_0000));
		for (int i = 0; i < 6; i++)
			pending_words.push_back(mk_word(CMD_REPORT, 1'b1, 32'h0010_0000 - 32'(i * 4096)));
		drain();

		// Random phases, each under its own register setting
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					write_register(REG_UCB_WEIGHT, 24'd0);
					write_register(REG_HISTORY_LENGTH, 24'd1);
				end
				1: begin
					write_register(REG_UCB_WEIGHT, 24'hFF_FFFF);
					write_register(REG_HISTORY_LENGTH, 24'd512);
				end
				2: begin
					write_register(REG_UCB_WEIGHT, 24'd65536);
					write_register(REG_HISTORY_LENGTH, 24'd0);
				end
				3: begin
					write_register(REG_UCB_WEIGHT, 24'($urandom()));
					write_register(REG_HISTORY_LENGTH, 24'h3FF);
					write_register(REG_UNUSED, 24'($urandom()));
				end
				4: begin
					write_register(REG_UCB_WEIGHT, 24'd20000);
					write_register(REG_HISTORY_LENGTH, 24'd7);
				end
				5: begin
					write_register(REG_UCB_WEIGHT, 24'($urandom_range(262144)));
					write_register(REG_HISTORY_LENGTH, 24'($urandom_range(512, 1)));
				end
				default: begin
					write_register(REG_UCB_WEIGHT, 24'($urandom()));
					write_register(REG_HISTORY_LENGTH, 24'($urandom()));
				end
			endcase
			queue_search(117);
			drain();
		end

		$display("covered %0d words: %0d results, %0d rejected, %0d new bests,",
			words_in, results_out, rejects_seen, bests_seen);
		$display("seven register settings including the extremes and one long output stall");
		if (errors == 0) begin
			$display("ucb_late_acceptance_controller: match");
		end else begin
			$display("ucb_late_acceptance_controller: mismatch");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(LIMIT_CYCLES * 20);
		$display("timeout with %0d results outstanding", outcome_q.size());
		$display("ucb_late_acceptance_controller: mismatch");
		$finish;
	end

endmodule
